### design/nca_pkg.sv
package nca_pkg;

  // Field widths of the request and result payloads
  localparam int unsigned CiW      = 4;
  localparam int unsigned EiW      = 8;
  localparam int unsigned ValW     = 16;
  localparam int unsigned ClW      = 4;
  localparam int unsigned SimW     = 32;
  localparam int unsigned KCfgW    = 5;
  localparam int unsigned DimCfgW  = 9;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned AccW     = 40;

  // Register reset values
  localparam logic [KCfgW-1:0]   K_RESET   = 5'd16;
  localparam logic [DimCfgW-1:0] DIM_RESET = 9'd256;

  // Running best starts at -2.0 in Q2.30
  localparam logic signed [SimW-1:0] BEST_START = 32'sh8000_0000;
  localparam logic signed [SimW-1:0] SIM_MAX    = 32'sh7fff_ffff;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_VECTOR = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_K_IN_USE   = 1'b0,
    CFG_DIM_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_CMP,
    ST_OUT
  } state_e;

  typedef struct packed {
    kind_e                  kind;
    logic [CiW-1:0]         centroid_index;
    logic [EiW-1:0]         element_index;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ClW-1:0]         cluster;
    logic signed [SimW-1:0] similarity;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_we;   // write one centroid element
    logic latch;     // capture the vector element
    logic step_clr;  // restart the step counter
    logic mac;       // multiply-accumulate sweep over the centroids
    logic cmp;       // compare sweep over the accumulators
    logic pos_inc;   // advance to the next element position
    logic finish;    // clear accumulators and position after a result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mac_done;
    logic cmp_done;
    logic vec_last;
  } stat_t;

endpackage

### design/nearest_centroid_cosine_assign.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+------------------------------
// request  | start, busy, req_i                      | taken when start && !busy
// result   | result_valid_o, result_o                | one-cycle strobe, no stall
// config   | cfg_we_i, cfg_idx_i, cfg_data_i         | written when cfg_we_i
//
// A load request writes the centroid store directly and busy stays low.
// A vector element makes k reads of the single centroid store read port through
// one shared multiplier, then drains the pipeline and, unless it is the last, returns to idle.
// The last element of a vector goes on to a compare sweep over the k accumulators and a result state.
// Reset clears the accumulators, position and state; the centroid store is not cleared.
// The receiver cannot stall: result_valid_o is high for exactly one cycle.
module nearest_centroid_cosine_assign #(
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned MAX_DIM      = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  nca_pkg::req_t                req_i,
  input  logic                         cfg_we_i,
  input  nca_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [nca_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         result_valid_o,
  output nca_pkg::res_t                result_o
);

  nca_pkg::cmd_t  cmd;
  nca_pkg::stat_t stat;

  // Sequencer
  nca_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .kind_i         (req_i.kind),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // Centroid store, multiply-accumulate and compare
  nca_dpath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIM      (MAX_DIM)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (result_o)
  );

endmodule

### design/nca_dpath.sv
module nca_dpath #(
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned MAX_DIM      = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nca_pkg::req_t                     req_i,
  input  logic                              cfg_we_i,
  input  nca_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [nca_pkg::CfgDataW-1:0]      cfg_data_i,
  input  nca_pkg::cmd_t                     cmd_i,
  output nca_pkg::stat_t                    stat_o,
  output nca_pkg::res_t                     result_o
);

  localparam int unsigned CW    = $clog2(MAX_CLUSTERS);
  localparam int unsigned CNTW  = CW + 1;
  localparam int unsigned PW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned DEPTH = MAX_CLUSTERS * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [nca_pkg::KCfgW-1:0]   k_cfg_q;
  logic [nca_pkg::DimCfgW-1:0] dim_cfg_q;
  logic [CNTW-1:0]             k_eff;
  logic [DW-1:0]               dim_eff;

  logic [PW-1:0]               pos_q;
  logic [CNTW-1:0]             cnt_q;
  logic signed [nca_pkg::ValW-1:0] val_q;

  logic signed [nca_pkg::ValW-1:0] cstore_mem [DEPTH];
  logic signed [nca_pkg::ValW-1:0] rdata_q;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic                        wr_ok;
  logic                        issue;

  logic                        s1_v_q, s2_v_q;
  logic [CW-1:0]               s1_idx_q, s2_idx_q;
  logic signed [nca_pkg::ProdW-1:0] prod_q;
  logic [nca_pkg::AccW-1:0]    acc_q [MAX_CLUSTERS];

  logic [nca_pkg::AccW-1:0]    cmp_acc;
  logic signed [nca_pkg::SimW-1:0] cmp_sat;
  logic                        cmp_first;
  logic signed [nca_pkg::SimW-1:0] base_best;
  logic [CW-1:0]               base_idx;
  logic signed [nca_pkg::SimW-1:0] best_q, best_d;
  logic [CW-1:0]               bidx_q, bidx_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q   <= nca_pkg::K_RESET;
      dim_cfg_q <= nca_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nca_pkg::CFG_K_IN_USE:   k_cfg_q   <= cfg_data_i[nca_pkg::KCfgW-1:0];
        nca_pkg::CFG_DIM_IN_USE: dim_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the registers into the supported range
  always_comb begin
    if (k_cfg_q == '0) begin
      k_eff = CNTW'(1);
    end else if (32'(k_cfg_q) > 32'(MAX_CLUSTERS)) begin
      k_eff = CNTW'(MAX_CLUSTERS);
    end else begin
      k_eff = CNTW'(k_cfg_q);
    end
    if (dim_cfg_q == '0) begin
      dim_eff = DW'(1);
    end else if (32'(dim_cfg_q) > 32'(MAX_DIM)) begin
      dim_eff = DW'(MAX_DIM);
    end else begin
      dim_eff = DW'(dim_cfg_q);
    end
  end

  assign stat_o.mac_done = (cnt_q == CNTW'(k_eff + CNTW'(1)));
  assign stat_o.cmp_done = (cnt_q == CNTW'(k_eff - CNTW'(1)));
  assign stat_o.vec_last = ((32'(pos_q) + 32'd1) >= 32'(dim_eff));

  // Centroid store addressing
  assign wr_ok   = (32'(req_i.centroid_index) < 32'(MAX_CLUSTERS)) &&
                   (32'(req_i.element_index) < 32'(MAX_DIM));
  assign wr_addr = AW'(32'(req_i.centroid_index) * MAX_DIM + 32'(req_i.element_index));
  assign rd_addr = AW'(32'(cnt_q[CW-1:0]) * MAX_DIM + 32'(pos_q));
  assign issue   = cmd_i.mac && (cnt_q < k_eff);

  // Centroid store: one write port for loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && wr_ok) begin
      cstore_mem[wr_addr] <= req_i.value;
    end
    if (issue) begin
      rdata_q <= cstore_mem[rd_addr];
    end
  end

  // Step counter and element position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      if (cmd_i.step_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.mac || cmd_i.cmp) begin
        cnt_q <= cnt_q + CNTW'(1);
      end
      if (cmd_i.finish) begin
        pos_q <= '0;
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + PW'(1);
      end
    end
  end

  // Hold the vector element for the sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      val_q <= req_i.value;
    end
  end

  // Pipeline valids: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= cnt_q[CW-1:0];
    s2_idx_q <= s1_idx_q;
    prod_q   <= nca_pkg::ProdW'(rdata_q) * nca_pkg::ProdW'(val_q);
  end

  // Accumulators: add one product a cycle, clear after the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (s2_v_q) begin
      acc_q[s2_idx_q] <= acc_q[s2_idx_q] +
                         {{(nca_pkg::AccW - nca_pkg::ProdW){prod_q[nca_pkg::ProdW-1]}}, prod_q};
    end
  end

  // Saturate the addressed accumulator and compare with the running best
  always_comb begin
    cmp_acc = acc_q[cnt_q[CW-1:0]];
    if ((&cmp_acc[nca_pkg::AccW-1:nca_pkg::SimW-1]) ||
        !(|cmp_acc[nca_pkg::AccW-1:nca_pkg::SimW-1])) begin
      cmp_sat = cmp_acc[nca_pkg::SimW-1:0];
    end else if (cmp_acc[nca_pkg::AccW-1]) begin
      cmp_sat = nca_pkg::BEST_START;
    end else begin
      cmp_sat = nca_pkg::SIM_MAX;
    end
    cmp_first = (cnt_q == '0);
    base_best = cmp_first ? nca_pkg::BEST_START : best_q;
    base_idx  = cmp_first ? '0 : bidx_q;
    // Strictly greater keeps the lowest index on ties
    if (cmp_sat > base_best) begin
      best_d = cmp_sat;
      bidx_d = cnt_q[CW-1:0];
    end else begin
      best_d = base_best;
      bidx_d = base_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      best_q <= best_d;
      bidx_q <= bidx_d;
    end
  end

  assign result_o.cluster    = nca_pkg::ClW'(bidx_q);
  assign result_o.similarity = best_q;

endmodule

### design/nca_ctrl.sv
module nca_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  nca_pkg::kind_e  kind_i,
  input  nca_pkg::stat_t  stat_i,
  output nca_pkg::cmd_t   cmd_o,
  output logic            busy,
  output logic            result_valid_o
);

  nca_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nca_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      nca_pkg::ST_IDLE: begin
        if (start) begin
          if (kind_i == nca_pkg::KIND_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.latch    = 1'b1;
            cmd_o.step_clr = 1'b1;
            state_d        = nca_pkg::ST_MAC;
          end
        end
      end
      nca_pkg::ST_MAC: begin
        cmd_o.mac = 1'b1;
        if (stat_i.mac_done) begin
          if (stat_i.vec_last) begin
            cmd_o.step_clr = 1'b1;
            state_d        = nca_pkg::ST_CMP;
          end else begin
            cmd_o.pos_inc = 1'b1;
            state_d       = nca_pkg::ST_IDLE;
          end
        end
      end
      nca_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (stat_i.cmp_done) begin
          state_d = nca_pkg::ST_OUT;
        end
      end
      nca_pkg::ST_OUT: begin
        cmd_o.finish = 1'b1;
        state_d      = nca_pkg::ST_IDLE;
      end
      default: begin
        state_d = nca_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != nca_pkg::ST_IDLE);
  assign result_valid_o = (state_q == nca_pkg::ST_OUT);

`ifndef ASSERT_OFF
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == nca_pkg::KIND_LOAD) |=> !busy)
    else $error("load request left the block busy");

  a_vector_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == nca_pkg::KIND_VECTOR) |=> state_q == nca_pkg::ST_MAC)
    else $error("vector request did not start the sweep");

  a_mid_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nca_pkg::ST_MAC && stat_i.mac_done && !stat_i.vec_last)
      |=> !busy && !result_valid_o)
    else $error("mid-vector element did not return to idle");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe held longer than one cycle");
`endif

endmodule

### test/nearest_centroid_cosine_assign_test.sv
`timescale 1ns / 100ps

module nearest_centroid_cosine_assign_test;

  localparam int unsigned MAX_CL         = 16;
  localparam int unsigned MAX_DM         = 256;
  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 7;
  // Extra wait after the block is idle and every result has been answered
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned TIMEOUT_CYCLES = 400_000;
  localparam int unsigned RANDOM_ITEMS   = 1100;

  localparam logic signed [nca_pkg::AccW-1:0] ACC_SAT_HI = 40'sh00_7fff_ffff;
  localparam logic signed [nca_pkg::AccW-1:0] ACC_SAT_LO = 40'shff_8000_0000;

  logic                         clk_i      = 1'b0;
  logic                         rst_ni     = 1'b0;
  logic                         start      = 1'b0;
  logic                         busy;
  nca_pkg::req_t                req_i      = '0;
  logic                         cfg_we_i   = 1'b0;
  nca_pkg::cfg_idx_e            cfg_idx_i  = nca_pkg::CFG_K_IN_USE;
  logic [nca_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         result_valid_o;
  nca_pkg::res_t                result_o;

  // Predicted block state
  logic signed [nca_pkg::ValW-1:0] centroid_table [MAX_CL][MAX_DM];
  logic [nca_pkg::AccW-1:0]        dot_acc [MAX_CL];
  int unsigned                     vector_pos = 0;
  logic [nca_pkg::KCfgW-1:0]       k_reg      = nca_pkg::K_RESET;
  logic [nca_pkg::DimCfgW-1:0]     dim_reg    = nca_pkg::DIM_RESET;

  // Stimulus side: which table entries hold data, and where the next element lands
  bit                     entry_loaded [MAX_CL][MAX_DM];
  int unsigned            gen_pos = 0;

  nca_pkg::req_t pending_requests[$];
  nca_pkg::res_t expected_assignments[$];
  int unsigned   requests_queued   = 0;
  int unsigned   requests_accepted = 0;
  int unsigned   sender_gap_pct    = 21;
  int unsigned   mismatch_count    = 0;

  nearest_centroid_cosine_assign #(
    .MAX_CLUSTERS(MAX_CL),
    .MAX_DIM     (MAX_DM)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned active_clusters(input logic [nca_pkg::KCfgW-1:0] k);
    if (k == 0) return 1;
    if (k > MAX_CL) return MAX_CL;
    return k;
  endfunction

  function automatic int unsigned active_dims(input logic [nca_pkg::DimCfgW-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DM) return MAX_DM;
    return d;
  endfunction

  // Apply one accepted request to the predicted state; queue the assignment at vector end
  function automatic void nearest_centroid_predict(input nca_pkg::req_t r);
    int unsigned                      kk;
    int unsigned                      p;
    int unsigned                      best_c;
    logic signed [nca_pkg::ProdW-1:0] prod;
    logic signed [nca_pkg::AccW-1:0]  acc_s;
    logic signed [nca_pkg::SimW-1:0]  sim;
    logic signed [nca_pkg::SimW-1:0]  best;
    nca_pkg::res_t                    hit;
    kk = active_clusters(k_reg);
    if (r.kind == nca_pkg::KIND_LOAD) begin
      centroid_table[r.centroid_index][r.element_index] = r.value;
    end else begin
      p = (vector_pos >= MAX_DM) ? MAX_DM - 1 : vector_pos;
      for (int c = 0; c < kk; c++) begin
        prod = nca_pkg::ProdW'($signed(r.value)) *
               nca_pkg::ProdW'($signed(centroid_table[c][p]));
        dot_acc[c] = dot_acc[c] +
                     {{(nca_pkg::AccW-nca_pkg::ProdW){prod[nca_pkg::ProdW-1]}}, prod};
      end
      if (vector_pos + 1 < active_dims(dim_reg)) begin
        vector_pos++;
      end else begin
        // Pick the strictly greatest saturated dot product, lowest index on ties
        best   = nca_pkg::BEST_START;
        best_c = 0;
        for (int c = 0; c < kk; c++) begin
          acc_s = $signed(dot_acc[c]);
          if (acc_s > ACC_SAT_HI) sim = nca_pkg::SIM_MAX;
          else if (acc_s < ACC_SAT_LO) sim = nca_pkg::BEST_START;
          else sim = acc_s[nca_pkg::SimW-1:0];
          if (sim > best) begin
            best   = sim;
            best_c = c;
          end
        end
        for (int c = 0; c < MAX_CL; c++) dot_acc[c] = '0;
        vector_pos     = 0;
        hit.cluster    = best_c[nca_pkg::ClW-1:0];
        hit.similarity = best;
        expected_assignments.push_back(hit);
      end
    end
  endfunction

  function automatic logic [nca_pkg::ValW-1:0] random_q15();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return nca_pkg::ValW'($urandom);
    endcase
  endfunction

  function automatic void queue_load(input int unsigned ci, input int unsigned ei,
                                     input logic [nca_pkg::ValW-1:0] v);
    nca_pkg::req_t r;
    r.kind           = nca_pkg::KIND_LOAD;
    r.centroid_index = ci[nca_pkg::CiW-1:0];
    r.element_index  = ei[nca_pkg::EiW-1:0];
    r.value          = v;
    entry_loaded[ci][ei] = 1'b1;
    pending_requests.push_back(r);
    requests_queued++;
  endfunction

  // Fill any table entry the element will read, then queue the element itself
  function automatic void queue_vector_element(input logic [nca_pkg::ValW-1:0] v);
    nca_pkg::req_t r;
    for (int c = 0; c < active_clusters(k_reg); c++) begin
      if (!entry_loaded[c][gen_pos]) queue_load(c, gen_pos, random_q15());
    end
    r.kind           = nca_pkg::KIND_VECTOR;
    r.centroid_index = nca_pkg::CiW'($urandom_range(15));
    r.element_index  = nca_pkg::EiW'($urandom_range(255));
    r.value          = v;
    pending_requests.push_back(r);
    requests_queued++;
    if (gen_pos + 1 >= active_dims(dim_reg)) gen_pos = 0;
    else gen_pos++;
  endfunction

  task automatic write_register(input nca_pkg::cfg_idx_e idx,
                                input logic [nca_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == nca_pkg::CFG_K_IN_USE) k_reg = data[nca_pkg::KCfgW-1:0];
    else dim_reg = data[nca_pkg::DimCfgW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every request is taken and answered, then let the block drain
  task automatic wait_block_idle();
    while (requests_accepted != requests_queued || busy === 1'b1 ||
           expected_assignments.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: present the next request, with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        nearest_centroid_predict(req_i);
        requests_accepted++;
      end
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          start <= 1'b1;
          req_i <= pending_requests.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    nca_pkg::res_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_assignments.size() == 0) begin
        $display("%0t: unexpected result cluster %0d similarity %0d",
                 $time, result_o.cluster, result_o.similarity);
        mismatch_count++;
      end else begin
        want = expected_assignments.pop_front();
        if (want.cluster !== result_o.cluster) begin
          $display("%0t: cluster expected %0d actual %0d",
                   $time, want.cluster, result_o.cluster);
          mismatch_count++;
        end
        if (want.similarity !== result_o.similarity) begin
          $display("%0t: similarity expected %0d actual %0d",
                   $time, want.similarity, result_o.similarity);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned                  phase_idx;
    int unsigned                  n;
    int unsigned                  directed_items;
    logic [nca_pkg::CfgDataW-1:0] k_data;
    logic [nca_pkg::CfgDataW-1:0] dim_data;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: saturation both ways, ties, zero vector, extreme load address
    write_register(nca_pkg::CFG_K_IN_USE, 9'd3);
    write_register(nca_pkg::CFG_DIM_IN_USE, 9'd3);
    for (int e = 0; e < 3; e++) begin
      queue_load(0, e, 16'h8000);
      queue_load(1, e, 16'h8000);
      queue_load(2, e, 16'h7fff);
    end
    queue_load(15, 255, 16'h7fff);
    repeat (3) queue_vector_element(16'h8000);
    repeat (3) queue_vector_element(16'h7fff);
    repeat (3) queue_vector_element(16'h0000);
    wait_block_idle();
    // Every active centroid saturates to the minimum: cluster 0 wins
    write_register(nca_pkg::CFG_K_IN_USE, 9'd2);
    repeat (3) queue_vector_element(16'h7fff);
    // Shrink the length mid-vector so the next element ends it
    repeat (2) queue_vector_element(16'h8000);
    wait_block_idle();
    write_register(nca_pkg::CFG_DIM_IN_USE, 9'd1);
    queue_vector_element(16'h8000);
    directed_items = requests_queued;

    // Random phases: new settings each time, gaps shift across the run
    phase_idx = 0;
    while (requests_queued - directed_items < RANDOM_ITEMS) begin
      if (requests_queued - directed_items < RANDOM_ITEMS / 3) sender_gap_pct = 21;
      else if (requests_queued - directed_items < 2 * RANDOM_ITEMS / 3) sender_gap_pct = 63;
      else sender_gap_pct = 0;
      wait_block_idle();
      case (phase_idx)
        0: begin
          k_data   = 9'h1ff;
          dim_data = 9'd2;
        end
        1: begin
          k_data   = 9'd0;
          dim_data = 9'd0;
        end
        2: begin
          k_data   = 9'd1;
          dim_data = 9'h1ff;
        end
        default: begin
          k_data   = nca_pkg::CfgDataW'($urandom_range(1, 16));
          dim_data = ($urandom_range(4) == 0) ? nca_pkg::CfgDataW'($urandom_range(9, 40))
                                              : nca_pkg::CfgDataW'($urandom_range(1, 8));
        end
      endcase
      write_register(nca_pkg::CFG_K_IN_USE, k_data);
      write_register(nca_pkg::CFG_DIM_IN_USE, dim_data);
      n = (phase_idx == 2) ? MAX_DM : $urandom_range(15, 60);
      repeat (n) begin
        if ($urandom_range(9) == 0)
          queue_load($urandom_range(15), $urandom_range(255), random_q15());
        else
          queue_vector_element(random_q15());
      end
      phase_idx++;
    end

    wait_block_idle();
    if (mismatch_count == 0 && expected_assignments.size() == 0) begin
      $display("** nearest_centroid_cosine_assign: PASSED **");
    end else begin
      $display("** nearest_centroid_cosine_assign: FAILED **");
    end
    $finish;
  end

  // Drop the run if it hangs
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("** nearest_centroid_cosine_assign: FAILED **");
    $finish;
  end

endmodule
